### rtl/otca_pkg.sv
// ----------------------------------------------------------------------------
// otca_pkg
// Shared sizes, register indexes, rule codes and helper functions for the
// outer-totalistic cellular automaton unit.
// ----------------------------------------------------------------------------
package otca_pkg;

   // Grid and neighbourhood limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 3;

   // Rows kept in the line store; also the side of the largest window
   localparam int DEPTH = 2 * MAX_RADIUS + 1;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int SPAN_W = RAD_W + 1;
   localparam int GSUM_W = $clog2(DEPTH + 1);
   localparam int SUM_W  = $clog2(DEPTH * DEPTH);

   // Fixed field and register widths
   localparam int MODE_W      = 2;
   localparam int RADIUS_W    = 2;
   localparam int BOUND_W     = 6;
   localparam int GRID_W      = 11;
   localparam int POS_W       = 10;
   localparam int COUNT_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   // Width for grid size compares
   localparam int SIZE_A = (COL_W + 1 > ROW_W + 1) ? COL_W + 1 : ROW_W + 1;
   localparam int SIZE_W = (GRID_W > SIZE_A) ? GRID_W : SIZE_A;

   // Width for count against bound compares
   localparam int CMP_W = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;

   // Largest neighbour count with a radius of one
   localparam int R1_MAX = 8;

   // Rule codes
   localparam logic [MODE_W-1:0] MODE_LIFE      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DAY_NIGHT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RANGED    = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RULE_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_MIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_MAX   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURVIVE_MIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURVIVE_MAX = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 3'd7;

   // Rule constants
   localparam int LIFE_BIRTH   = 3;
   localparam int LIFE_KEEP    = 2;
   localparam int DN_KEEP      = 4;
   localparam int DN_BIRTH_A   = 3;
   localparam int DN_BIRTH_B   = 6;
   localparam int DN_BIRTH_C   = 7;
   localparam int DN_BIRTH_D   = 8;

   // One bit per line store row slot, for one column
   typedef logic [DEPTH-1:0]  colvec_type;
   typedef logic [GSUM_W-1:0] gsum_type;

   // (a - b) modulo DEPTH, both below DEPTH
   function automatic logic [SLOT_W-1:0] ring_sub(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] t;
      if (a >= b) begin
         t = {1'b0, a} - {1'b0, b};
      end else begin
         t = {1'b0, a} + (SLOT_W + 1)'(DEPTH) - {1'b0, b};
      end
      return SLOT_W'(t);
   endfunction

   // Zero reads as one, anything above the maximum as the maximum
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [GRID_W-1:0] v,
                                                    input int maxv);
      logic [SIZE_W-1:0] ve;
      ve = SIZE_W'(v);
      if (v == '0) begin
         return SIZE_W'(1);
      end
      if (int'(ve) > maxv) begin
         return SIZE_W'(maxv);
      end
      return ve;
   endfunction

   function automatic logic rule_next(input logic [MODE_W-1:0]  mode,
                                      input logic               alive,
                                      input logic [SUM_W-1:0]   n,
                                      input logic [BOUND_W-1:0] bmin,
                                      input logic [BOUND_W-1:0] bmax,
                                      input logic [BOUND_W-1:0] smin,
                                      input logic [BOUND_W-1:0] smax);
      logic [CMP_W-1:0] ne;
      logic             res;
      ne = CMP_W'(n);
      unique case (mode)
         MODE_DAY_NIGHT: begin
            res = (int'(n) == DN_BIRTH_A) || (int'(n) == DN_BIRTH_B) ||
                  (int'(n) == DN_BIRTH_C) || (int'(n) == DN_BIRTH_D) ||
                  (alive && (int'(n) == DN_KEEP));
         end
         MODE_RANGED: begin
            if (alive) begin
               res = (ne >= CMP_W'(smin)) && (ne <= CMP_W'(smax));
            end else begin
               res = (ne >= CMP_W'(bmin)) && (ne <= CMP_W'(bmax));
            end
         end
         default: begin
            // Life, and the unused code
            res = (int'(n) == LIFE_BIRTH) || (alive && (int'(n) == LIFE_KEEP));
         end
      endcase
      return res;
   endfunction

endpackage

### rtl/outer_totalistic_cellular_automaton_unit.sv
// ----------------------------------------------------------------------------
// outer_totalistic_cellular_automaton_unit
// Streaming next-generation engine: raster cells in, interior cell states out.
// ----------------------------------------------------------------------------
// Path: a result reaches the output register after the store read,
//   write-back, masking and two adder levels.
// Throughput: one cell per cycle unless the output stalls; set by the single
//   read-modify-write of the column-organised line store, one column word per cell.
// Reset: synchronous; clears position, window and registers to their defaults.
//   The line store is not cleared: its contents are undefined until written.
module outer_totalistic_cellular_automaton_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cell_alive,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_next_alive,
   output logic [otca_pkg::POS_W-1:0]         rsp_cell_row,
   output logic [otca_pkg::POS_W-1:0]         rsp_cell_col,
   output logic [otca_pkg::COUNT_W-1:0]       rsp_neighbour_count,
   input  logic                               csr_we,
   input  logic [otca_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [otca_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import otca_pkg::*;

   // Registers
   logic [MODE_W-1:0]   rule_mode_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [BOUND_W-1:0]  birth_min_ff, birth_max_ff, survive_min_ff, survive_max_ff;
   logic [GRID_W-1:0]   grid_width_ff, grid_height_ff;

   // Effective settings
   logic [RADIUS_W-1:0] r_sel;
   logic [RAD_W-1:0]    r_eff;
   logic [SPAN_W-1:0]   span;
   logic [SIZE_W-1:0]   w_eff, h_eff;

   // Position
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ROW_W-1:0]  s0_row;
   logic [COL_W-1:0]  s0_col;
   logic [SLOT_W-1:0] s0_slot;
   logic              s0_rep;
   logic [SIZE_W-1:0] col_inc, row_inc;

   logic en, accept;

   // Line store: one word per column, one bit per row slot
   colvec_type line_mem [MAX_WIDTH];
   colvec_type rd_ff;

   // Stage 1: read data back, merge new cell
   logic              s1_valid_ff, s1_rep_ff, s1_alive_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [POS_W-1:0]  s1_prow_ff, s1_pcol_ff;
   colvec_type        s1_vec;

   // Window of recent column words, [0] newest
   colvec_type win_ff [DEPTH];

   // Stage 2: masking
   logic              s2_valid_ff, s2_rep_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic [SLOT_W-1:0] s2_slot_ff;
   logic [POS_W-1:0]  s2_prow_ff, s2_pcol_ff;
   logic [SLOT_W-1:0] cslot;
   colvec_type        s2_bits [DEPTH];
   logic              s2_centre;

   // Stage 3: per-column counts
   logic              s3_rep_ff, s3_centre_ff;
   logic [POS_W-1:0]  s3_prow_ff, s3_pcol_ff;
   colvec_type        s3_bits_ff [DEPTH];
   gsum_type          s3_gsum [DEPTH];

   // Stage 4: total and rule
   logic              s4_rep_ff, s4_centre_ff;
   logic [POS_W-1:0]  s4_prow_ff, s4_pcol_ff;
   gsum_type          s4_gsum_ff [DEPTH];
   logic [SUM_W-1:0]  s4_total;
   logic              s4_next;

   // Output register
   logic               rsp_valid_ff;
   logic               rsp_next_ff;
   logic [POS_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // ------------------------------------------------------------------------
   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_mode_ff   <= MODE_LIFE;
         radius_ff      <= RADIUS_W'(1);
         birth_min_ff   <= BOUND_W'(3);
         birth_max_ff   <= BOUND_W'(3);
         survive_min_ff <= BOUND_W'(2);
         survive_max_ff <= BOUND_W'(3);
         grid_width_ff  <= GRID_W'(1024);
         grid_height_ff <= GRID_W'(1024);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RULE_MODE:   rule_mode_ff   <= MODE_W'(csr_wdata);
            CSR_RADIUS:      radius_ff      <= RADIUS_W'(csr_wdata);
            CSR_BIRTH_MIN:   birth_min_ff   <= BOUND_W'(csr_wdata);
            CSR_BIRTH_MAX:   birth_max_ff   <= BOUND_W'(csr_wdata);
            CSR_SURVIVE_MIN: survive_min_ff <= BOUND_W'(csr_wdata);
            CSR_SURVIVE_MAX: survive_max_ff <= BOUND_W'(csr_wdata);
            CSR_GRID_WIDTH:  grid_width_ff  <= GRID_W'(csr_wdata);
            CSR_GRID_HEIGHT: grid_height_ff <= GRID_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rule_mode_ff == MODE_RANGED) begin
         r_sel = (radius_ff == '0) ? RADIUS_W'(1) : radius_ff;
      end else begin
         r_sel = RADIUS_W'(1);
      end
      r_eff = (int'(r_sel) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_sel);
   end

   assign span  = {r_eff, 1'b0};
   assign w_eff = clamp_size(grid_width_ff, MAX_WIDTH);
   assign h_eff = clamp_size(grid_height_ff, MAX_HEIGHT);

   // ------------------------------------------------------------------------
   // Handshake: only a result landing on an untaken one stalls the pipe
   assign en        = !(rsp_valid_ff && !rsp_ready && s4_rep_ff);
   assign req_ready = en;
   assign accept    = req_valid && en;

   // ------------------------------------------------------------------------
   // Stage 0: position and store read
   always_comb begin
      s0_row  = req_frame_start ? '0 : row_ff;
      s0_col  = req_frame_start ? '0 : col_ff;
      s0_slot = req_frame_start ? '0 : slot_ff;

      s0_rep = (SIZE_W'(s0_row) >= SIZE_W'(span)) && (SIZE_W'(s0_col) >= SIZE_W'(span)) &&
               (SIZE_W'(s0_row) < h_eff) && (SIZE_W'(s0_col) < w_eff);

      col_inc = SIZE_W'(s0_col) + SIZE_W'(1);
      row_inc = SIZE_W'(s0_row) + SIZE_W'(1);

      row_in  = row_ff;
      col_in  = col_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (col_inc >= w_eff) begin
            col_in = '0;
            if (row_inc >= h_eff) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = ROW_W'(row_inc);
               slot_in = (s0_slot == SLOT_W'(DEPTH - 1)) ? '0 : s0_slot + SLOT_W'(1);
            end
         end else begin
            col_in  = COL_W'(col_inc);
            row_in  = s0_row;
            slot_in = s0_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[s0_col];
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         line_mem[s1_col_ff] <= s1_vec;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: merge. The word written on the edge this read was issued is
   // missed by the read, so take it from the window head.
   always_comb begin
      s1_vec = (s2_valid_ff && (s2_col_ff == s1_col_ff)) ? win_ff[0] : rd_ff;
      s1_vec[s1_slot_ff] = s1_alive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_rep_ff   <= 1'b0;
         s3_rep_ff   <= 1'b0;
         s4_rep_ff   <= 1'b0;
         for (int k = 0; k < DEPTH; k++) begin
            win_ff[k] <= '0;
         end
      end else if (en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s2_rep_ff   <= s1_valid_ff && s1_rep_ff;
         s3_rep_ff   <= s2_rep_ff;
         s4_rep_ff   <= s3_rep_ff;
         if (s1_valid_ff) begin
            win_ff[0] <= s1_vec;
            for (int k = 1; k < DEPTH; k++) begin
               win_ff[k] <= win_ff[k-1];
            end
         end
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (en) begin
         s1_rep_ff    <= s0_rep;
         s1_alive_ff  <= req_cell_alive;
         s1_col_ff    <= s0_col;
         s1_slot_ff   <= s0_slot;
         s1_prow_ff   <= POS_W'(s0_row - ROW_W'(r_eff));
         s1_pcol_ff   <= POS_W'(s0_col - COL_W'(r_eff));

         s2_col_ff    <= s1_col_ff;
         s2_slot_ff   <= s1_slot_ff;
         s2_prow_ff   <= s1_prow_ff;
         s2_pcol_ff   <= s1_pcol_ff;

         s3_centre_ff <= s2_centre;
         s3_prow_ff   <= s2_prow_ff;
         s3_pcol_ff   <= s2_pcol_ff;
         for (int k = 0; k < DEPTH; k++) begin
            s3_bits_ff[k] <= s2_bits[k];
            s4_gsum_ff[k] <= s3_gsum[k];
         end

         s4_centre_ff <= s3_centre_ff;
         s4_prow_ff   <= s3_prow_ff;
         s4_pcol_ff   <= s3_pcol_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: keep window columns 0..span and the last span+1 rows, drop centre
   assign cslot = ring_sub(s2_slot_ff, SLOT_W'(r_eff));

   always_comb begin
      s2_centre = 1'b0;
      for (int k = 0; k < DEPTH; k++) begin
         for (int s = 0; s < DEPTH; s++) begin
            if ((k == int'(r_eff)) && (SLOT_W'(s) == cslot)) begin
               s2_bits[k][s] = 1'b0;
               s2_centre     = s2_centre | win_ff[k][s];
            end else begin
               s2_bits[k][s] = win_ff[k][s] && (k <= int'(span)) &&
                               (int'(ring_sub(s2_slot_ff, SLOT_W'(s))) <= int'(span));
            end
         end
      end
   end

   // Stage 3: count each column
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         s3_gsum[k] = '0;
         for (int s = 0; s < DEPTH; s++) begin
            s3_gsum[k] = s3_gsum[k] + GSUM_W'(s3_bits_ff[k][s]);
         end
      end
   end

   // Stage 4: add columns, apply rule
   always_comb begin
      s4_total = '0;
      for (int k = 0; k < DEPTH; k++) begin
         s4_total = s4_total + SUM_W'(s4_gsum_ff[k]);
      end
      s4_next = rule_next(rule_mode_ff, s4_centre_ff, s4_total, birth_min_ff,
                          birth_max_ff, survive_min_ff, survive_max_ff);
   end

   // ------------------------------------------------------------------------
   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && s4_rep_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && s4_rep_ff) begin
         rsp_next_ff  <= s4_next;
         rsp_row_ff   <= s4_prow_ff;
         rsp_col_ff   <= s4_pcol_ff;
         rsp_count_ff <= COUNT_W'(s4_total);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_alive      = rsp_next_ff;
   assign rsp_cell_row        = rsp_row_ff;
   assign rsp_cell_col        = rsp_col_ff;
   assign rsp_neighbour_count = rsp_count_ff;

   // ------------------------------------------------------------------------
   // Assertions
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(DEPTH - 1))
      else $error("row slot out of range");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && s4_rep_ff) |-> !req_ready)
      else $error("beat taken while a result would be overwritten");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_rep_ff))
      else $error("result raised without a reporting cell");

   a_small_count: assert property (@(posedge clock) disable iff (reset)
      (s4_rep_ff && (rule_mode_ff != MODE_RANGED)) |-> (int'(s4_total) <= R1_MAX))
      else $error("radius one count too large");

endmodule
